// ----- rtl/b64d_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
// Used by the front, queue, back and top level files; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

	localparam logic [7:0] PAD_CODE   = 8'h3D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_LEN  = 2'd1;
	localparam logic [1:0] ST_BAD_PAD  = 2'd2;
	localparam logic [1:0] ST_BAD_CHAR = 2'd3;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef logic [QUEUE_AW-1:0] qptr_t;
	typedef logic [QUEUE_CW-1:0] qcnt_t;

	// Classified character as it travels from front to back
	typedef struct packed {
		logic       is_pad;
		logic       is_bad;
		logic [5:0] sextet;
		logic       last;
	} item_t;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_text;
		logic [1:0] status;
	} res_t;

	// Queue handshake status: ready is seen by the front, valid by the back
	typedef struct packed {
		logic ready;
		logic valid;
	} q_stat_t;

	// Map a character to 0..63, or 64 when it is outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b0, d[5:0]};
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h47;
			return {1'b0, d[5:0]};
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'h04;
			return {1'b0, d[5:0]};
		end
		if (c == CHAR_PLUS) return 7'd62;
		if (c == CHAR_SLASH) return 7'd63;
		return 7'd64;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/b64d_front.sv -----
// Front stage: accepts characters, classifies them and hands them to the queue.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         char_code,
	input  wire logic               last_char,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire b64d_pkg::q_stat_t  q_stat,
	output logic                    valid_s1,
	output b64d_pkg::item_t         item_s1
);

	logic [6:0] sx;
	logic       push;

	assign push     = valid_s1 && q_stat.ready;
	assign in_ready = !valid_s1 || q_stat.ready;
	assign sx       = b64d_pkg::sextet_of(char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.is_pad <= (char_code == b64d_pkg::PAD_CODE);
			item_s1.is_bad <= sx[6];
			item_s1.sextet <= sx[5:0];
			item_s1.last   <= last_char;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/b64d_queue.sv -----
// Short item queue between the front and back stages.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64d_pkg::item_t  push_item,
	input  wire logic             pop,
	output b64d_pkg::q_stat_t     stat,
	output b64d_pkg::item_t       head_item,
	output b64d_pkg::qcnt_t       count
);

	b64d_pkg::item_t mem_q [b64d_pkg::QUEUE_DEPTH];
	b64d_pkg::qptr_t wr_ptr_q;
	b64d_pkg::qptr_t rd_ptr_q;
	b64d_pkg::qcnt_t count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.ready = (count_q != b64d_pkg::qcnt_t'(b64d_pkg::QUEUE_DEPTH));
	assign stat.valid = (count_q != '0);
	assign do_push    = push && stat.ready;
	assign do_pop     = pop && stat.valid;
	assign head_item  = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + b64d_pkg::qptr_t'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + b64d_pkg::qptr_t'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + b64d_pkg::qcnt_t'(1);
				2'b01:   count_q <= count_q - b64d_pkg::qcnt_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ----- rtl/b64d_back.sv -----
// Back stage: decoder state, byte extraction, end-of-text status and output register.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire b64d_pkg::item_t  head_item,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output b64d_pkg::res_t        out_res
);

	logic [11:0] acc_q;
	logic [3:0]  pend_bits_q;
	logic [1:0]  len_q;
	logic        pad_seen_q;
	logic [1:0]  pad_cnt_q;
	logic        pad_err_q;
	logic        bad_err_q;

	logic [11:0] acc_n;
	logic [3:0]  pend_bits_n;
	logic [1:0]  len_n;
	logic        pad_seen_n;
	logic [1:0]  pad_cnt_n;
	logic        pad_err_n;
	logic        bad_err_n;

	logic [11:0] acc_shift;
	logic [3:0]  pend_sum;
	logic [2:0]  sh;
	logic [11:0] shifted;
	logic        has_byte;
	logic [1:0]  st;

	b64d_pkg::res_t out_q;
	logic           out_valid_q;
	b64d_pkg::res_t hold_q;
	logic           hold_valid_q;
	logic           out_free;
	b64d_pkg::res_t byte_res;
	b64d_pkg::res_t stat_res;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = head_valid && !hold_valid_q && out_free;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign acc_shift = {acc_q[5:0], head_item.sextet};
	assign pend_sum  = pend_bits_q + 4'd6;
	assign sh        = 3'(pend_sum - 4'd8);
	assign shifted   = acc_shift >> sh;

	always_comb begin
		acc_n       = acc_q;
		pend_bits_n = pend_bits_q;
		len_n       = len_q + 2'd1;
		pad_seen_n  = pad_seen_q;
		pad_cnt_n   = pad_cnt_q;
		pad_err_n   = pad_err_q;
		bad_err_n   = bad_err_q;
		has_byte    = 1'b0;
		if (pad_seen_q) begin
			if (head_item.is_pad) begin
				if (pad_cnt_q != 2'd3) pad_cnt_n = pad_cnt_q + 2'd1;
				if (pad_cnt_n == 2'd3) pad_err_n = 1'b1;
			end else begin
				pad_err_n = 1'b1;
			end
		end else if (head_item.is_pad) begin
			pad_seen_n = 1'b1;
			pad_cnt_n  = 2'd1;
		end else if (head_item.is_bad) begin
			bad_err_n = 1'b1;
		end else if (!bad_err_q && !pad_err_q) begin
			acc_n = acc_shift;
			if (pend_sum >= 4'd8) begin
				has_byte    = 1'b1;
				pend_bits_n = pend_sum - 4'd8;
			end else begin
				pend_bits_n = pend_sum;
			end
		end

		priority if (len_n != 2'd0) st = b64d_pkg::ST_BAD_LEN;
		else if (pad_err_n) st = b64d_pkg::ST_BAD_PAD;
		else if (bad_err_n) st = b64d_pkg::ST_BAD_CHAR;
		else st = b64d_pkg::ST_OK;

		byte_res.out_byte    = shifted[7:0];
		byte_res.byte_valid  = 1'b1;
		byte_res.end_of_text = 1'b0;
		byte_res.status      = b64d_pkg::ST_OK;
		stat_res.out_byte    = 8'h00;
		stat_res.byte_valid  = 1'b0;
		stat_res.end_of_text = 1'b1;
		stat_res.status      = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pend_bits_q <= '0;
			len_q       <= '0;
			pad_seen_q  <= 1'b0;
			pad_cnt_q   <= '0;
			pad_err_q   <= 1'b0;
			bad_err_q   <= 1'b0;
		end else if (pop) begin
			if (head_item.last) begin
				// end of text: back to the reset state
				acc_q       <= '0;
				pend_bits_q <= '0;
				len_q       <= '0;
				pad_seen_q  <= 1'b0;
				pad_cnt_q   <= '0;
				pad_err_q   <= 1'b0;
				bad_err_q   <= 1'b0;
			end else begin
				acc_q       <= acc_n;
				pend_bits_q <= pend_bits_n;
				len_q       <= len_n;
				pad_seen_q  <= pad_seen_n;
				pad_cnt_q   <= pad_cnt_n;
				pad_err_q   <= pad_err_n;
				bad_err_q   <= bad_err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (hold_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (pop && (has_byte || head_item.last)) begin
				out_valid_q  <= 1'b1;
				// byte goes out first, status waits in the hold slot
				hold_valid_q <= has_byte && head_item.last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_valid_q && out_free) begin
			out_q <= hold_q;
		end else if (pop && has_byte) begin
			out_q  <= byte_res;
			hold_q <= stat_res;
		end else if (pop && head_item.last) begin
			out_q <= stat_res;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_decoder_core.sv -----
// Top level of the base64 stream decoder: front stage, item queue and back stage.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes standard-alphabet base64 text at one character per clock, sustained,
// while out_ready stays high. A character passes the front register, a four-entry
// queue and the back stage's output register before its byte appears. A character
// that both completes a byte and ends the text gives two result items, the byte
// first and then the status from a hold slot; the queue absorbs that and short
// output stalls. Every text ends with one status item (end_of_text = 1): 0 ok, 1
// length not a multiple of four, 2 bad padding, 3 character outside the alphabet.
// Discard the bytes of a text whose status is nonzero.
module base64_stream_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            end_of_text,
	output logic [1:0]      status,
	output logic            out_valid,
	input  wire logic       out_ready
);

	b64d_pkg::q_stat_t q_stat;
	b64d_pkg::item_t   item_s1;
	b64d_pkg::item_t   head_item;
	b64d_pkg::qcnt_t   q_count;
	b64d_pkg::res_t    out_res;
	logic              valid_s1;
	logic              pop;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.last_char (last_char),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.q_stat    (q_stat),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_item (item_s1),
		.pop       (pop),
		.stat      (q_stat),
		.head_item (head_item),
		.count     (q_count)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_stat.valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

	assign out_byte    = out_res.out_byte;
	assign byte_valid  = out_res.byte_valid;
	assign end_of_text = out_res.end_of_text;
	assign status      = out_res.status;

	// a full queue with a waiting front item must stall the input
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !q_stat.ready |-> !in_ready)
		else $error("input accepted while front stage is blocked");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= b64d_pkg::qcnt_t'(b64d_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_item_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_valid != end_of_text))
		else $error("result item is neither a byte nor a status");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("back stage took an item from an empty queue");

endmodule

`default_nettype wire

// ----- test/base64_stream_decoder_core_tb.sv -----
// Self-checking testbench for base64_stream_decoder_core: directed texts, then random texts.
// Expected items come from an in-bench decoder model; depends on b64d_pkg and the core RTL.
`timescale 1ns / 1ps

module base64_stream_decoder_core_tb;

	localparam int IDLE_PCT      = 14;
	localparam int ITEM_GOAL     = 1050;
	localparam int PAUSE_STEP    = 350;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 16;
	localparam int DIR_ROWS      = 23;

	// One row of the directed table; typed rows carry the status of the text they end
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		logic [1:0] st;
	} stim_row_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic [7:0] char_code   = 8'h00;
	logic       last_char   = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_text;
	logic [1:0] status;
	logic       out_valid;
	logic       out_ready   = 1'b0;

	// Decoder model state
	bit [11:0] acc_bits;
	bit [3:0]  acc_count;
	bit [1:0]  char_phase;
	bit        pad_seen;
	bit [1:0]  pad_count;
	bit        pad_err;
	bit        char_err;

	b64d_pkg::res_t decoded_q[$];
	logic [7:0]     text_q[$];
	stim_row_t      dir_rows [0:DIR_ROWS-1];

	int errors      = 0;
	int items_sent  = 0;
	int cycle_count = 0;
	bit calm        = 1'b0;

	base64_stream_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.last_char   (last_char),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.end_of_text (end_of_text),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bit 6 set means the code is outside the alphabet
	function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
		if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
		if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
		if (c == "+") return 7'd62;
		if (c == "/") return 7'd63;
		return 7'h40;
	endfunction

	function automatic logic [7:0] sextet_to_char(input int unsigned s);
		if (s < 26) return 8'("A" + s);
		if (s < 52) return 8'("a" + s - 26);
		if (s < 62) return 8'("0" + s - 52);
		return (s == 62) ? "+" : "/";
	endfunction

	// Advance the model by one character and queue the items it yields
	task automatic decode_char(input logic [7:0] ch, input logic last);
		logic [6:0]  sx;
		logic [11:0] shifted;
		logic [1:0]  st;
		char_phase = char_phase + 2'd1;
		if (pad_seen) begin
			if (ch == b64d_pkg::PAD_CODE) begin
				if (pad_count != 2'd3) pad_count = pad_count + 2'd1;
				if (pad_count == 2'd3) pad_err = 1'b1;
			end else begin
				pad_err = 1'b1;
			end
		end else if (ch == b64d_pkg::PAD_CODE) begin
			pad_seen  = 1'b1;
			pad_count = 2'd1;
		end else begin
			sx = char_to_sextet(ch);
			if (sx[6]) begin
				char_err = 1'b1;
			end else if (!char_err && !pad_err) begin
				acc_bits  = {acc_bits[5:0], sx[5:0]};
				acc_count = acc_count + 4'd6;
				if (acc_count >= 4'd8) begin
					acc_count = acc_count - 4'd8;
					shifted   = acc_bits >> acc_count;
					decoded_q.insert(decoded_q.size(),
						{shifted[7:0], 1'b1, 1'b0, b64d_pkg::ST_OK});
				end
			end
		end
		if (last) begin
			// length beats padding, padding beats bad character
			if (char_phase != 2'd0) st = b64d_pkg::ST_BAD_LEN;
			else if (pad_err) st = b64d_pkg::ST_BAD_PAD;
			else if (char_err) st = b64d_pkg::ST_BAD_CHAR;
			else st = b64d_pkg::ST_OK;
			decoded_q.insert(decoded_q.size(), {8'h00, 1'b0, 1'b1, st});
			acc_bits   = '0;
			acc_count  = '0;
			char_phase = '0;
			pad_seen   = 1'b0;
			pad_count  = '0;
			pad_err    = 1'b0;
			char_err   = 1'b0;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
			input logic [1:0] st);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= ch;
		last_char <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_char(ch, last);
		// typed rows put their own status on the item just queued
		if (typed)
			decoded_q[decoded_q.size() - 1].status = st;
		items_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every queued item has come out
	task automatic wait_drained();
		while (decoded_q.size() != 0) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Mostly well-formed texts, some with one corruption, the rest noise
	task automatic build_text();
		int kind;
		int groups;
		int pads;
		int pos;
		text_q.delete();
		kind = $urandom_range(99);
		if (kind < 85) begin
			groups = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
			for (int i = 0; i < groups * 4; i++)
				text_q.insert(text_q.size(), sextet_to_char($urandom_range(63)));
			pads = $urandom_range(2);
			for (int i = 1; i <= pads; i++)
				text_q[text_q.size() - i] = b64d_pkg::PAD_CODE;
			if (kind >= 70) begin
				pos = $urandom_range(text_q.size() - 1);
				case ($urandom_range(3))
				0: text_q[pos] = 8'($urandom_range(255));
				1: text_q.delete(pos);
				2: text_q.insert(pos, b64d_pkg::PAD_CODE);
				default: text_q.insert(text_q.size(), b64d_pkg::PAD_CODE);
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 9)) begin
				case ($urandom_range(2))
				0: text_q.insert(text_q.size(), 8'($urandom_range(255)));
				1: text_q.insert(text_q.size(), sextet_to_char($urandom_range(63)));
				default: text_q.insert(text_q.size(), b64d_pkg::PAD_CODE);
				endcase
			end
		end
	endtask

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : check_out
		b64d_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				$error({"item with nothing expected: out_byte %0h byte_valid %0b ",
					"end_of_text %0b status %0d"},
					out_byte, byte_valid, end_of_text, status);
				errors++;
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
					errors++;
				end
				if (byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
					errors++;
				end
				if (end_of_text !== want.end_of_text) begin
					$error("end_of_text: expected %0b, got %0b", want.end_of_text, end_of_text);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int drain;
		int next_pause;
		dir_rows = '{
			// lone pad: length error
			'{8'h3D, 1'b1, 1'b1, b64d_pkg::ST_BAD_LEN},
			// all ones
			'{"/", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{"/", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{"/", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{"/", 1'b1, 1'b1, b64d_pkg::ST_OK},
			// two pads, four bits left over
			'{"Q", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{"Q", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b1, 1'b1, b64d_pkg::ST_OK},
			// third pad
			'{"A", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b1, 1'b1, b64d_pkg::ST_BAD_PAD},
			// bad character and bad padding together
			'{8'hFF, 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h3D, 1'b1, 1'b1, b64d_pkg::ST_BAD_PAD},
			// bad character only
			'{"A", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{"z", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{"+", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h80, 1'b1, 1'b1, b64d_pkg::ST_BAD_CHAR},
			// short text with a bad character
			'{"z", 1'b0, 1'b0, b64d_pkg::ST_OK},
			'{8'h7F, 1'b1, 1'b1, b64d_pkg::ST_BAD_LEN}
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].st);

		next_pause = PAUSE_STEP;
		while (items_sent < ITEM_GOAL) begin
			calm = (items_sent >= 450 && items_sent < 650);
			if (items_sent >= next_pause) begin
				wait_drained();
				next_pause += PAUSE_STEP;
			end
			build_text();
			foreach (text_q[i])
				send_char(text_q[i], i == text_q.size() - 1, 1'b0, b64d_pkg::ST_OK);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		drain = 0;
		while (decoded_q.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (decoded_q.size() != 0) begin
			$error("%0d expected items never came out", decoded_q.size());
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
